// ----- src/ign_pkg.sv -----
package ign_pkg;

    // Register widths
    localparam int RPM_W    = 14;
    localparam int DWELL_W  = 13;
    localparam int MODE_W   = 2;
    localparam int BURST_W  = 4;
    localparam int DEAD_W   = 11;
    localparam int CNT_W    = 32;
    localparam int PHASE_W  = 19;
    localparam int CFG_IDX_W = 3;

    // Period division: 60e6 / rpm, one quotient bit per step
    localparam int DIV_NUM_W = 26;
    localparam logic [DIV_NUM_W-1:0] DIV_NUM = 26'd60000000;
    localparam int DIV_STEP_W = $clog2(DIV_NUM_W);

    // Clamp limits
    localparam logic [RPM_W-1:0]   RPM_MAX   = 14'd12000;
    localparam logic [RPM_W-1:0]   RPM_MIN   = 14'd200;
    localparam logic [PHASE_W-1:0] PERIOD_MIN = 19'd5000;
    localparam logic [DWELL_W-1:0] DWELL_MAX = 13'd5000;
    localparam logic [DWELL_W-1:0] DWELL_MIN = 13'd200;
    localparam logic [PHASE_W-1:0] DWELL_MARGIN = 19'd500;

    // Register reset values
    localparam logic [RPM_W-1:0]   RST_RPM   = 14'd1000;
    localparam logic [DWELL_W-1:0] RST_DWELL = 13'd2000;
    localparam logic [MODE_W-1:0]  RST_MODE  = 2'd0;
    localparam logic [BURST_W-1:0] RST_BURST = 4'd10;
    localparam logic [DEAD_W-1:0]  RST_DEAD  = 11'd1500;
    localparam logic [DEAD_W-1:0]  SINCE_SAT = '1;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_START = 2'd1,
        OP_STOP  = 2'd2
    } t_op;

    typedef enum logic [MODE_W-1:0] {
        MODE_CONT    = 2'd0,
        MODE_GROUP   = 2'd1,
        MODE_ONESHOT = 2'd2,
        MODE_RAMP    = 2'd3
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RPM   = 3'd0,
        CFG_DWELL = 3'd1,
        CFG_MODE  = 3'd2,
        CFG_BURST = 3'd3,
        CFG_DEAD  = 3'd4
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_FIN
    } t_state;

    typedef struct packed {
        logic exec;     // apply a tick, stop or unused opcode and load the result
        logic div_go;   // latch a start item and launch the period division
        logic fin;      // finish a start item and load the result
    } t_cmd;

    typedef struct packed {
        logic out_free;
        logic div_done;
    } t_stat;

endpackage

// ----- src/ign_div.sv -----
module ign_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_go,
    input  logic [ign_pkg::RPM_W-1:0]  i_divisor,
    output logic [ign_pkg::PHASE_W-1:0] o_quot,
    output logic                       o_done
);
    import ign_pkg::*;

    logic [DIV_NUM_W-1:0]  r_num, n_num;
    logic [DIV_NUM_W-1:0]  r_quo, n_quo;
    logic [RPM_W-1:0]      r_den;
    logic [RPM_W-1:0]      r_rem, n_rem;
    logic [DIV_STEP_W-1:0] r_step, n_step;
    logic                  r_busy, n_busy;
    logic                  r_done, n_done;
    logic [RPM_W:0]        rem_sh;
    logic                  fits;

    // One restoring step per cycle, MSB first
    always_comb begin
        rem_sh = {r_rem, r_num[DIV_NUM_W-1]};
        fits   = rem_sh >= {1'b0, r_den};
        n_num  = r_num;
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_step = r_step;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_go) begin
            n_num  = DIV_NUM;
            n_quo  = '0;
            n_rem  = '0;
            n_step = '0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_num = {r_num[DIV_NUM_W-2:0], 1'b0};
            n_quo = {r_quo[DIV_NUM_W-2:0], fits};
            n_rem = fits ? RPM_W'(rem_sh - {1'b0, r_den}) : rem_sh[RPM_W-1:0];
            if (r_step == DIV_STEP_W'(DIV_NUM_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end else begin
                n_step = r_step + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_step <= n_step;
        end
        r_num <= n_num;
        r_quo <= n_quo;
        r_rem <= n_rem;
        if (i_go) begin
            r_den <= i_divisor;
        end
    end

    assign o_quot = r_quo[PHASE_W-1:0];
    assign o_done = r_done;

endmodule

// ----- src/ign_dp.sv -----
module ign_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  ign_pkg::t_cmd                 i_cmd,
    output ign_pkg::t_stat                o_stat,
    input  logic                          i_cfg_valid,
    input  logic [ign_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]                   i_cfg_data,
    input  logic [1:0]                    i_opcode,
    input  logic                          i_spark_edge,
    input  logic                          i_out_stall,
    output logic                          o_out_valid,
    output logic                          o_gate_drive,
    output logic                          o_is_running,
    output logic [31:0]                   o_fired_count,
    output logic [31:0]                   o_spark_count,
    output logic [31:0]                   o_missed_count,
    output logic                          o_auto_stopped
);
    import ign_pkg::*;

    // Configuration
    logic [RPM_W-1:0]   r_rpm;
    logic [DWELL_W-1:0] r_dwell;
    logic [MODE_W-1:0]  r_mode;
    logic [BURST_W-1:0] r_burst;
    logic [DEAD_W-1:0]  r_dead;

    // Pulse train state
    logic               r_gate, n_gate;
    logic               r_run, n_run;
    logic [PHASE_W-1:0] r_phase, n_phase;
    logic [DWELL_W-1:0] r_on_tgt, n_on_tgt;
    logic [PHASE_W-1:0] r_off_tgt, n_off_tgt;
    logic [BURST_W-1:0] r_left, n_left;
    logic [CNT_W-1:0]   r_fired, n_fired;
    logic [CNT_W-1:0]   r_spark, n_spark;
    logic [DEAD_W-1:0]  r_since, n_since;
    logic               r_edge_hold;

    // Result register
    logic               r_out_valid;
    logic               r_o_gate, r_o_run, r_o_auto;
    logic [CNT_W-1:0]   r_o_fired, r_o_spark, r_o_missed;
    logic               n_auto;
    logic               edge_in;
    logic               load;

    // Start arithmetic
    logic [RPM_W-1:0]   rpm_c;
    logic [PHASE_W-1:0] quot;
    logic               div_done;
    logic [PHASE_W-1:0] period;
    logic [PHASE_W-1:0] max_dw;
    logic [DWELL_W-1:0] dw_c;
    logic [DWELL_W-1:0] dw;
    logic [BURST_W-1:0] budget;

    always_comb begin
        if (r_rpm > RPM_MAX) begin
            rpm_c = RPM_MAX;
        end else if (r_rpm < RPM_MIN) begin
            rpm_c = RPM_MIN;
        end else begin
            rpm_c = r_rpm;
        end
    end

    ign_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_go      (i_cmd.div_go),
        .i_divisor (rpm_c),
        .o_quot    (quot),
        .o_done    (div_done)
    );

    always_comb begin
        period = (quot < PERIOD_MIN) ? PERIOD_MIN : quot;
        max_dw = period - DWELL_MARGIN;
        if (r_dwell > DWELL_MAX) begin
            dw_c = DWELL_MAX;
        end else if (r_dwell < DWELL_MIN) begin
            dw_c = DWELL_MIN;
        end else begin
            dw_c = r_dwell;
        end
        dw = ({6'd0, dw_c} > max_dw) ? max_dw[DWELL_W-1:0] : dw_c;
        case (r_mode)
            MODE_ONESHOT: budget = BURST_W'(1);
            MODE_GROUP:   budget = (r_burst == '0) ? BURST_W'(1) : r_burst;
            default:      budget = '0;
        endcase
    end

    always_comb begin
        n_gate    = r_gate;
        n_run     = r_run;
        n_phase   = r_phase;
        n_on_tgt  = r_on_tgt;
        n_off_tgt = r_off_tgt;
        n_left    = r_left;
        n_fired   = r_fired;
        n_spark   = r_spark;
        n_since   = r_since;
        n_auto    = 1'b0;
        edge_in   = 1'b0;
        if (i_cmd.exec) begin
            edge_in = i_spark_edge;
            case (i_opcode)
                OP_TICK: begin
                    if (r_since != SINCE_SAT) begin
                        n_since = r_since + 1'b1;
                    end
                    if (r_run) begin
                        n_phase = r_phase + 1'b1;
                        if (r_gate) begin
                            if (n_phase >= {6'd0, r_on_tgt}) begin
                                n_gate  = 1'b0;
                                n_phase = '0;
                                n_fired = r_fired + 1'b1;
                                if (r_left != '0) begin
                                    n_left = r_left - 1'b1;
                                    if (r_left == BURST_W'(1)) begin
                                        n_run  = 1'b0;
                                        n_auto = 1'b1;
                                    end
                                end
                            end
                        end else if (n_phase >= r_off_tgt) begin
                            n_gate  = 1'b1;
                            n_phase = '0;
                        end
                    end
                end
                OP_STOP: begin
                    n_gate  = 1'b0;
                    n_run   = 1'b0;
                    n_left  = '0;
                    n_phase = '0;
                end
                default: begin
                end
            endcase
        end
        if (i_cmd.fin) begin
            edge_in   = r_edge_hold;
            n_on_tgt  = dw;
            n_off_tgt = period - {6'd0, dw};
            n_fired   = '0;
            n_spark   = '0;
            n_left    = budget;
            n_gate    = 1'b1;
            n_run     = 1'b1;
            n_phase   = '0;
        end
        // Judge the spark edge last, against the advanced elapsed count
        if (edge_in && (n_since >= r_dead)) begin
            n_since = '0;
            n_spark = n_spark + 1'b1;
        end
    end

    assign load = i_cmd.exec | i_cmd.fin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rpm       <= RST_RPM;
            r_dwell     <= RST_DWELL;
            r_mode      <= RST_MODE;
            r_burst     <= RST_BURST;
            r_dead      <= RST_DEAD;
            r_gate      <= 1'b0;
            r_run       <= 1'b0;
            r_phase     <= '0;
            r_on_tgt    <= '0;
            r_off_tgt   <= '0;
            r_left      <= '0;
            r_fired     <= '0;
            r_spark     <= '0;
            r_since     <= SINCE_SAT;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_RPM:   r_rpm   <= i_cfg_data[RPM_W-1:0];
                    CFG_DWELL: r_dwell <= i_cfg_data[DWELL_W-1:0];
                    CFG_MODE:  r_mode  <= i_cfg_data[MODE_W-1:0];
                    CFG_BURST: r_burst <= i_cfg_data[BURST_W-1:0];
                    CFG_DEAD:  r_dead  <= i_cfg_data[DEAD_W-1:0];
                    default: begin
                    end
                endcase
            end
            r_gate    <= n_gate;
            r_run     <= n_run;
            r_phase   <= n_phase;
            r_on_tgt  <= n_on_tgt;
            r_off_tgt <= n_off_tgt;
            r_left    <= n_left;
            r_fired   <= n_fired;
            r_spark   <= n_spark;
            r_since   <= n_since;
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
        if (i_cmd.div_go) begin
            r_edge_hold <= i_spark_edge;
        end
        if (load) begin
            r_o_gate   <= n_gate;
            r_o_run    <= n_run;
            r_o_auto   <= n_auto;
            r_o_fired  <= n_fired;
            r_o_spark  <= n_spark;
            r_o_missed <= (n_fired > n_spark) ? n_fired - n_spark : '0;
        end
    end

    assign o_stat.out_free = !r_out_valid || !i_out_stall;
    assign o_stat.div_done = div_done;

    assign o_out_valid    = r_out_valid;
    assign o_gate_drive   = r_o_gate;
    assign o_is_running   = r_o_run;
    assign o_fired_count  = r_o_fired;
    assign o_spark_count  = r_o_spark;
    assign o_missed_count = r_o_missed;
    assign o_auto_stopped = r_o_auto;

endmodule

// ----- src/ign_ctrl.sv -----
module ign_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic [1:0]     i_opcode,
    input  ign_pkg::t_stat i_stat,
    output logic           o_in_stall,
    output ign_pkg::t_cmd  o_cmd
);
    import ign_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                o_in_stall = !i_stat.out_free;
                if (i_in_valid && i_stat.out_free) begin
                    if (i_opcode == OP_START) begin
                        o_cmd.div_go = 1'b1;
                        n_state      = ST_DIV;
                    end else begin
                        o_cmd.exec = 1'b1;
                    end
                end
            end
            ST_DIV: begin
                if (i_stat.div_done) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (i_stat.out_free) begin
                    o_cmd.fin = 1'b1;
                    n_state   = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- src/ignition_dwell_pulse_generator_core.sv -----
// Channel   Direction  Handshake                 Payload
// input     in         i_in_valid / o_in_stall   i_opcode, i_spark_edge
// result    out        o_out_valid / i_out_stall o_gate_drive, o_is_running,
//                                                o_fired_count, o_spark_count,
//                                                o_missed_count, o_auto_stopped
// config    in         i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// Tick, stop and unused-opcode items go back to back while the result register
// drains. A start item passes through launch, 26 divider steps, a state that sees
// the divider finish, and the finish that loads the result once output is free.
// Reset is synchronous, active low; it restores register defaults and saturates
// the spark elapsed counter, so the first edge always counts. Input stalls while
// the result register is full and stalled or while a start item is in progress.
module ignition_dwell_pulse_generator_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [1:0]                    i_opcode,
    input  logic                          i_spark_edge,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_gate_drive,
    output logic                          o_is_running,
    output logic [31:0]                   o_fired_count,
    output logic [31:0]                   o_spark_count,
    output logic [31:0]                   o_missed_count,
    output logic                          o_auto_stopped,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [ign_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]                   i_cfg_data
);
    import ign_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    // Registers are to be written only while idle (the block does not enforce this), so always take the write
    assign o_cfg_ready = 1'b1;

    // Sequence items: ticks, stops and unused opcodes directly, starts through the divider
    ign_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_opcode   (i_opcode),
        .i_stat     (stat),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    // Hold pulse train state, counters, config and the result register
    ign_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_opcode       (i_opcode),
        .i_spark_edge   (i_spark_edge),
        .i_out_stall    (i_out_stall),
        .o_out_valid    (o_out_valid),
        .o_gate_drive   (o_gate_drive),
        .o_is_running   (o_is_running),
        .o_fired_count  (o_fired_count),
        .o_spark_count  (o_spark_count),
        .o_missed_count (o_missed_count),
        .o_auto_stopped (o_auto_stopped)
    );

endmodule

// ----- tb/sv/testbench.sv -----
module testbench;
    import ign_pkg::*;

    // Opcode and register index that the block must ignore
    localparam logic [1:0]           OP_UNUSED = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_NONE  = 3'd7;

    // Pulse timing floors and fallbacks
    localparam int ON_MIN_TICKS    = 100;
    localparam int OFF_MIN_TICKS   = 400;
    localparam int FALLBACK_TICKS  = 1000;
    localparam int SHORT_PERIOD    = 600;
    localparam int SHORT_DWELL_CAP = 100;

    // Run shape
    localparam int IDLE_PCT      = 14;
    localparam int SETTLE_CYCLES = 40;
    localparam int EPISODES      = 60;
    localparam int ITEM_BUDGET   = 750;
    localparam int SHOT_TICKS    = 210;
    localparam int TIME_LIMIT    = 10000000;

    typedef struct packed {
        logic [1:0] op;
        logic       spark;
    } t_coil_item;

    typedef struct packed {
        logic        gate;
        logic        running;
        logic [31:0] fired;
        logic [31:0] sparks;
        logic [31:0] missed;
        logic        auto_stop;
    } t_coil_status;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_stall;
    t_coil_item           shown     = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic                 gate_drive;
    logic                 is_running;
    logic [31:0]          fired_count;
    logic [31:0]          spark_count;
    logic [31:0]          missed_count;
    logic                 auto_stopped;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0]          cfg_data  = '0;

    // Items waiting to be driven, and the status each accepted item should produce
    t_coil_item   pending_q[$];
    t_coil_status status_q[$];

    bit calm          = 1'b0;  // suppress idling on both sides
    int mismatches    = 0;
    int results_seen  = 0;

    // Register copies, at their reset values
    logic [RPM_W-1:0]   cfg_rpm   = RST_RPM;
    logic [DWELL_W-1:0] cfg_dwell = RST_DWELL;
    t_mode              cfg_mode  = t_mode'(RST_MODE);
    logic [BURST_W-1:0] cfg_burst = RST_BURST;
    logic [DEAD_W-1:0]  cfg_dead  = RST_DEAD;

    // Pulse train state, at its reset values
    logic               gate_on     = 1'b0;
    logic               train_on    = 1'b0;
    logic [PHASE_W-1:0] phase       = '0;
    logic [PHASE_W-1:0] period      = '0;
    logic [DWELL_W-1:0] dwell       = '0;
    logic [BURST_W-1:0] pulses_left = '0;
    logic [CNT_W-1:0]   fired       = '0;
    logic [CNT_W-1:0]   sparks      = '0;
    logic [DEAD_W-1:0]  since_spark = SINCE_SAT;

    ignition_dwell_pulse_generator_core dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_opcode       (shown.op),
        .i_spark_edge   (shown.spark),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_gate_drive   (gate_drive),
        .o_is_running   (is_running),
        .o_fired_count  (fired_count),
        .o_spark_count  (spark_count),
        .o_missed_count (missed_count),
        .o_auto_stopped (auto_stopped),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data)
    );

    initial begin
        forever #1 clk = ~clk;
    end

    // Drop the pulse train; counters stay as they are
    function automatic void halt_train();
        gate_on     = 1'b0;
        train_on    = 1'b0;
        pulses_left = '0;
        phase       = '0;
    endfunction

    // Advance the pulse train by one item and return the status it leaves
    function automatic t_coil_status step_coil(input t_coil_item it);
        t_coil_status st;
        int           on_len, off_len, rpm, per, dw, max_dw;
        logic         budget_out;
        budget_out = 1'b0;
        case (it.op)
            OP_TICK: begin
                if (since_spark != SINCE_SAT) since_spark = since_spark + 1'b1;
                if (train_on) begin
                    phase   = phase + 1'b1;
                    on_len  = (dwell == 0) ? FALLBACK_TICKS : int'(dwell);
                    if (on_len < ON_MIN_TICKS) on_len = ON_MIN_TICKS;
                    off_len = (int'(period) > int'(dwell)) ? int'(period) - int'(dwell)
                                                           : FALLBACK_TICKS;
                    if (off_len < OFF_MIN_TICKS) off_len = OFF_MIN_TICKS;
                    if (gate_on) begin
                        // Gate-off completes one pulse and may spend the budget
                        if (int'(phase) >= on_len) begin
                            gate_on = 1'b0;
                            phase   = '0;
                            fired   = fired + 1'b1;
                            if (pulses_left != 0) begin
                                pulses_left = pulses_left - 1'b1;
                                if (pulses_left == 0) begin
                                    halt_train();
                                    budget_out = 1'b1;
                                end
                            end
                        end
                    end else if (int'(phase) >= off_len) begin
                        gate_on = 1'b1;
                        phase   = '0;
                    end
                end
            end
            OP_START: begin
                // Latch period and dwell from the registers, clamped
                rpm = int'(cfg_rpm);
                if (rpm > int'(RPM_MAX)) rpm = int'(RPM_MAX);
                if (rpm < int'(RPM_MIN)) rpm = int'(RPM_MIN);
                per = int'(DIV_NUM) / rpm;
                if (per < int'(PERIOD_MIN)) per = int'(PERIOD_MIN);
                dw = int'(cfg_dwell);
                if (dw > int'(DWELL_MAX)) dw = int'(DWELL_MAX);
                if (dw < int'(DWELL_MIN)) dw = int'(DWELL_MIN);
                max_dw = (per > SHORT_PERIOD) ? per - int'(DWELL_MARGIN) : SHORT_DWELL_CAP;
                if (dw > max_dw) dw = max_dw;
                period = PHASE_W'(per);
                dwell  = DWELL_W'(dw);
                fired  = '0;
                sparks = '0;
                if (cfg_mode == MODE_ONESHOT) pulses_left = BURST_W'(1);
                else if (cfg_mode == MODE_GROUP)
                    pulses_left = (cfg_burst != 0) ? cfg_burst : BURST_W'(1);
                else pulses_left = '0;
                gate_on  = 1'b1;
                train_on = 1'b1;
                phase    = '0;
            end
            OP_STOP: halt_train();
            default: ;
        endcase

        // Judge the spark edge last, after any counter clear
        if (it.spark && since_spark >= cfg_dead) begin
            since_spark = '0;
            sparks      = sparks + 1'b1;
        end

        st.gate      = gate_on;
        st.running   = train_on;
        st.fired     = fired;
        st.sparks    = sparks;
        st.missed    = (fired > sparks) ? fired - sparks : '0;
        st.auto_stop = budget_out;
        return st;
    endfunction

    function automatic void check_field(input string what, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            if (mismatches < 10)
                $display("result %0d: %s expected %0d, got %0d", results_seen, what, want, got);
            mismatches++;
        end
    endfunction

    // Input driver: hold the item while stalled, predict at acceptance, idle at random
    always @(posedge clk) begin : drive_items
        logic       show_next;
        t_coil_item nxt;
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            show_next = in_valid;
            if (in_valid && !in_stall) begin
                status_q.push_back(step_coil(shown));
                show_next = 1'b0;
            end
            if (!show_next && pending_q.size() != 0 &&
                (calm || $urandom_range(99) >= IDLE_PCT)) begin
                nxt       = pending_q.pop_front();
                shown    <= nxt;
                show_next = 1'b1;
            end
            in_valid <= show_next;
        end
    end

    // Result monitor: compare each accepted status with the oldest prediction
    always @(posedge clk) begin : watch_status
        t_coil_status got, want;
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (out_valid && !out_stall) begin
                got = '{gate_drive, is_running, fired_count, spark_count, missed_count,
                        auto_stopped};
                if (status_q.size() == 0) begin
                    if (mismatches < 10)
                        $display("result %0d: arrived with no item outstanding", results_seen);
                    mismatches++;
                end else begin
                    want = status_q.pop_front();
                    check_field("gate_drive",   32'(want.gate),      32'(got.gate));
                    check_field("is_running",   32'(want.running),   32'(got.running));
                    check_field("fired_count",  want.fired,          got.fired);
                    check_field("spark_count",  want.sparks,         got.sparks);
                    check_field("missed_count", want.missed,         got.missed);
                    check_field("auto_stopped", 32'(want.auto_stop), 32'(got.auto_stop));
                end
                results_seen++;
            end
            out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
        end
    end

    task automatic queue_item(input logic [1:0] op, input logic spark);
        pending_q.push_back('{op, spark});
    endtask

    // Wait until every queued item is accepted and every status has arrived
    task automatic drain();
        @(posedge clk);
        while (pending_q.size() != 0 || in_valid || status_q.size() != 0) @(posedge clk);
    endtask

    // Write one register; mirror it once the handshake completes
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        case (idx)
            CFG_RPM:   cfg_rpm   = data[RPM_W-1:0];
            CFG_DWELL: cfg_dwell = data[DWELL_W-1:0];
            CFG_MODE:  cfg_mode  = t_mode'(data[MODE_W-1:0]);
            CFG_BURST: cfg_burst = data[BURST_W-1:0];
            CFG_DEAD:  cfg_dead  = data[DEAD_W-1:0];
            default: ;
        endcase
        cfg_valid <= 1'b0;
    endtask

    initial begin : stimulus
        int          ep, i, n, r, total, spark_pct;
        logic [1:0]  op;
        logic [31:0] data;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings: first edge counts from the saturated counter, the next
        // is inside the dead time; unused opcode only judges the edge; a start
        // clears counters before its own edge is judged; stop keeps counters.
        queue_item(OP_TICK, 1'b1);
        queue_item(OP_TICK, 1'b1);
        queue_item(OP_UNUSED, 1'b1);
        queue_item(OP_STOP, 1'b0);
        queue_item(OP_START, 1'b1);
        queue_item(OP_TICK, 1'b0);
        queue_item(OP_STOP, 1'b0);
        drain();

        // Top of the rpm field, lowest dwell, burst with zero pulses, no dead time
        write_reg(CFG_RPM, 32'hFFFF_FFFF);
        write_reg(CFG_DWELL, 32'h0);
        write_reg(CFG_MODE, 32'(MODE_GROUP));
        write_reg(CFG_BURST, 32'h0);
        write_reg(CFG_DEAD, 32'h0);
        queue_item(OP_START, 1'b1);
        queue_item(OP_TICK, 1'b1);
        queue_item(OP_UNUSED, 1'b1);
        queue_item(OP_STOP, 1'b1);
        queue_item(OP_START, 1'b0);
        drain();

        // Slowest speed, top of the dwell field, single shot, widest dead time
        write_reg(CFG_RPM, 32'h0);
        write_reg(CFG_DWELL, 32'hFFFF_E000 | 32'h1FFF);
        write_reg(CFG_MODE, 32'(MODE_ONESHOT));
        write_reg(CFG_BURST, 32'hF);
        write_reg(CFG_DEAD, 32'h7FF);
        queue_item(OP_START, 1'b1);
        queue_item(OP_TICK, 1'b0);
        queue_item(OP_UNUSED, 1'b0);
        queue_item(OP_STOP, 1'b0);
        drain();

        // Fastest clamp with dwell trimmed to the period margin, sweep mode,
        // and a write to an index that holds no register
        write_reg(CFG_RPM, 32'(RPM_MAX));
        write_reg(CFG_DWELL, 32'(DWELL_MAX));
        write_reg(CFG_MODE, 32'(MODE_RAMP));
        write_reg(CFG_DEAD, 32'h1);
        write_reg(CFG_NONE, 32'hFFFF_FFFF);
        queue_item(OP_START, 1'b0);
        queue_item(OP_TICK, 1'b1);
        queue_item(OP_TICK, 1'b1);
        queue_item(OP_STOP, 1'b0);
        drain();

        // Shortest dwell in single shot: run through the gate-off that spends
        // the budget, then tick on while stopped
        write_reg(CFG_DWELL, 32'h0);
        write_reg(CFG_MODE, 32'(MODE_ONESHOT));
        queue_item(OP_START, 1'b0);
        for (i = 0; i < SHOT_TICKS; i++) queue_item(OP_TICK, (i % 50) == 49);

        // Random episodes: mostly a start followed by a run of ticks with
        // sparks at a per-episode rate, sprinkled with stops, restarts and noise
        total = 0;
        for (ep = 0; ep < EPISODES && total < ITEM_BUDGET; ep++) begin
            drain();
            calm = (ep >= 1 && ep < 3);

            if (ep == 0 || $urandom_range(99) < 60) begin
                if ($urandom_range(1)) begin
                    data = $urandom();
                    case ($urandom_range(5))
                        0: data[RPM_W-1:0] = RPM_W'($urandom_range(199));
                        1: data[RPM_W-1:0] = RPM_MAX;
                        2: data[RPM_W-1:0] = RPM_W'($urandom_range(16383, 12001));
                        3: data[RPM_W-1:0] = RPM_W'($urandom_range(12000, 6000));
                        4: data[RPM_W-1:0] = RPM_W'($urandom_range(12000, 9000));
                        default: data[RPM_W-1:0] = RPM_W'($urandom());
                    endcase
                    write_reg(CFG_RPM, data);
                end
                if ($urandom_range(1)) begin
                    data = $urandom();
                    case ($urandom_range(4))
                        0: data[DWELL_W-1:0] = DWELL_W'($urandom_range(200));
                        1: data[DWELL_W-1:0] = DWELL_W'($urandom_range(400, 200));
                        2: data[DWELL_W-1:0] = DWELL_W'($urandom_range(5000, 4400));
                        3: data[DWELL_W-1:0] = DWELL_W'($urandom_range(8191, 5001));
                        default: data[DWELL_W-1:0] = DWELL_W'($urandom());
                    endcase
                    write_reg(CFG_DWELL, data);
                end
                if ($urandom_range(1)) write_reg(CFG_MODE, $urandom());
                if ($urandom_range(1)) write_reg(CFG_BURST, $urandom());
                if ($urandom_range(1)) begin
                    data = $urandom();
                    case ($urandom_range(4))
                        0: data[DEAD_W-1:0] = '0;
                        1: data[DEAD_W-1:0] = DEAD_W'($urandom_range(50, 1));
                        2: data[DEAD_W-1:0] = DEAD_W'($urandom_range(2046, 200));
                        3: data[DEAD_W-1:0] = SINCE_SAT;
                        default: data[DEAD_W-1:0] = DEAD_W'($urandom());
                    endcase
                    write_reg(CFG_DEAD, data);
                end
                if ($urandom_range(19) == 0) write_reg(CFG_NONE, $urandom());
            end

            case ($urandom_range(4))
                0: spark_pct = 0;
                1: spark_pct = 2;
                2: spark_pct = 10;
                3: spark_pct = 50;
                default: spark_pct = 100;
            endcase

            // Short runs probe starts and stops; longer ones reach the first
            // gate-off when the dwell is short
            r = $urandom_range(99);
            if (r < 40) n = $urandom_range(40, 1);
            else if (r < 85) n = $urandom_range(320, 201);
            else n = $urandom_range(450, 321);
            if (n > ITEM_BUDGET - total) n = ITEM_BUDGET - total;

            if ($urandom_range(9) != 0) queue_item(OP_START, 1'($urandom_range(1)));
            for (i = 0; i < n; i++) begin
                r = $urandom_range(999);
                if (r < 2) op = OP_STOP;
                else if (r < 4) op = OP_START;
                else if (r < 6) op = OP_UNUSED;
                else op = OP_TICK;
                queue_item(op, $urandom_range(99) < spark_pct);
            end
            if ($urandom_range(1)) queue_item(OP_STOP, 1'($urandom_range(1)));
            total += n + 2;
        end

        // Let everything land, then give the block time to show stray results
        drain();
        calm = 1'b0;
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0) begin
            $display("** ignition_dwell_pulse_generator_core: PASSED **");
        end else begin
            $display("** ignition_dwell_pulse_generator_core: FAILED **");
        end
        $finish;
    end

    // Hard stop for a hung handshake
    initial begin
        #(TIME_LIMIT);
        $display("** ignition_dwell_pulse_generator_core: FAILED **");
        $finish;
    end

endmodule

// ----- ignition_dwell_pulse_generator_core.f -----
src/ign_pkg.sv
src/ign_div.sv
src/ign_dp.sv
src/ign_ctrl.sv
src/ignition_dwell_pulse_generator_core.sv
tb/sv/testbench.sv
